// ===== src/stirrer_pump_interlock_controller_top_macros.svh =====
// Assertion helpers shared by the controller RTL.
// Every check is sampled on i_clk and switched off while i_rst_n is low.
`ifndef STIRRER_PUMP_INTERLOCK_CONTROLLER_TOP_MACROS_SVH
`define STIRRER_PUMP_INTERLOCK_CONTROLLER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPIC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// The consequent must hold in the cycle after the antecedent.
`define SPIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== src/spic_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// spic_pkg
// Shared constants of the stirrer and pump interlock controller.
// -----------------------------------------------------------------------------
package spic_pkg;

    localparam int TICKS_PER_MINUTE = 6000;
    localparam int TICKS_PER_SECOND = 100;

    localparam int REG_W        = 10;
    localparam int STIR_TICKS_W = 13;
    localparam int LOW_TICKS_W  = 17;
    localparam int MINUTES_W    = 10;
    localparam int STATUS_W     = 4;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;

    localparam logic [REG_W-1:0] REG_MAX = REG_W'(999);

    // Register indexes.
    localparam logic REG_STIR_RUN_MINUTES = 1'b0;
    localparam logic REG_LOW_LEVEL_DELAY  = 1'b1;

    // Status codes, from lowest to highest priority.
    localparam logic [STATUS_W-1:0] ST_IDLE         = 4'd0;
    localparam logic [STATUS_W-1:0] ST_STIR_RUNNING = 4'd1;
    localparam logic [STATUS_W-1:0] ST_STIR_FAULT   = 4'd2;
    localparam logic [STATUS_W-1:0] ST_PUMP_RUNNING = 4'd3;
    localparam logic [STATUS_W-1:0] ST_PUMP_FAULT   = 4'd4;
    localparam logic [STATUS_W-1:0] ST_BOTH_RUNNING = 4'd5;
    localparam logic [STATUS_W-1:0] ST_BOTH_FAULTED = 4'd6;
    localparam logic [STATUS_W-1:0] ST_LOW_LIQUID   = 4'd7;
    localparam logic [STATUS_W-1:0] ST_POWER_FAULT  = 4'd8;
    localparam logic [STATUS_W-1:0] ST_STIR_TIMED   = 4'd9;
    localparam logic [STATUS_W-1:0] ST_BOTH_TIMED   = 4'd10;

    typedef logic [STATUS_W-1:0] t_status;

endpackage
`default_nettype wire

// ===== src/spic_in_if.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// spic_in_if
// Tick request channel: one request carries the sampled button and fault levels.
// -----------------------------------------------------------------------------
interface spic_in_if;
    logic valid;
    logic ready;
    logic stir_button_down;
    logic pump_button_down;
    logic stir_fault;
    logic pump_fault;
    logic power_fault;
    logic level_low;
    logic alarm_clear_down;

    modport source (
        output valid, stir_button_down, pump_button_down, stir_fault, pump_fault,
               power_fault, level_low, alarm_clear_down,
        input  ready
    );
    modport sink (
        input  valid, stir_button_down, pump_button_down, stir_fault, pump_fault,
               power_fault, level_low, alarm_clear_down,
        output ready
    );
endinterface
`default_nettype wire

// ===== src/spic_out_if.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// spic_out_if
// Result channel: relay drives, buzzer, alarm flag and status of one tick.
// -----------------------------------------------------------------------------
interface spic_out_if
    import spic_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 stir_relay_on;
    logic                 pump_relay_on;
    logic                 buzzer_on;
    logic                 alarm_active;
    logic [STATUS_W-1:0]  status_code;
    logic [MINUTES_W-1:0] minutes_left;

    modport source (
        output valid, stir_relay_on, pump_relay_on, buzzer_on, alarm_active,
               status_code, minutes_left,
        input  ready
    );
    modport sink (
        input  valid, stir_relay_on, pump_relay_on, buzzer_on, alarm_active,
               status_code, minutes_left,
        output ready
    );
endinterface
`default_nettype wire

// ===== src/stirrer_pump_interlock_controller_top.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// stirrer_pump_interlock_controller_top
// Stirrer and pump interlock: button toggles, fault stops, alarm latch, timer.
// -----------------------------------------------------------------------------
// Each tick request (one per 10 ms in the application) is handled by a
// control pass that runs in combinational logic from the state registers and
// the request fields, and its result lands in one output register. A request
// is accepted every cycle while the output register is
// empty or being taken in the same cycle, so the sustained rate is one tick
// per clock; the output register is the only thing that holds off the next
// request. Registers stir_run_minutes (address 0x0) and
// low_level_delay_seconds (address 0x4) are written through the APB port,
// 10 bits each; values above 999 act as 999.
`include "stirrer_pump_interlock_controller_top_macros.svh"

module stirrer_pump_interlock_controller_top
    import spic_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    spic_in_if.sink                i_tick,
    spic_out_if.source             o_res
);

    // Configuration registers.
    logic [REG_W-1:0] r_stir_minutes;
    logic [REG_W-1:0] r_low_delay;

    // Control state.
    logic                    r_stir_run;
    logic                    r_pump_run;
    logic                    r_stir_up;
    logic                    r_pump_up;
    logic [LOW_TICKS_W-1:0]  r_low_ticks;
    logic                    r_low_alarm;
    logic                    r_latch;
    logic [STIR_TICKS_W-1:0] r_stir_ticks;
    logic [MINUTES_W-1:0]    r_stir_min;

    // Output register.
    logic                 r_out_valid;
    logic                 r_out_stir;
    logic                 r_out_pump;
    logic                 r_out_buzz;
    logic                 r_out_alarm;
    t_status              r_out_status;
    logic [MINUTES_W-1:0] r_out_left;

    // Next values of the control pass.
    logic                    n_stir_run;
    logic                    n_pump_run;
    logic [LOW_TICKS_W-1:0]  n_low_ticks;
    logic                    n_low_alarm;
    logic                    n_latch;
    logic [STIR_TICKS_W-1:0] n_stir_ticks;
    logic [MINUTES_W-1:0]    n_stir_min;
    logic                    n_stir_relay;
    logic                    n_pump_relay;
    t_status                 n_status;
    logic [MINUTES_W-1:0]    n_left;

    logic                    cfg_wr;
    logic                    accept;
    logic [REG_W-1:0]        limit;
    logic [REG_W-1:0]        delay;
    logic [LOW_TICKS_W-1:0]  low_thr;
    logic [STIR_TICKS_W-1:0] stir_inc;
    logic [LOW_TICKS_W-1:0]  low_inc;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stir_minutes <= '0;
            r_low_delay    <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_STIR_RUN_MINUTES: r_stir_minutes <= pwdata[REG_W-1:0];
                REG_LOW_LEVEL_DELAY:  r_low_delay    <= pwdata[REG_W-1:0];
                default:              r_stir_minutes <= r_stir_minutes;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_STIR_RUN_MINUTES: prdata = DATA_W'(r_stir_minutes);
            REG_LOW_LEVEL_DELAY:  prdata = DATA_W'(r_low_delay);
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------ handshake
    assign i_tick.ready = !r_out_valid || o_res.ready;
    assign accept       = i_tick.valid && i_tick.ready;

    // --------------------------------------------------------- control pass
    assign limit    = (r_stir_minutes > REG_MAX) ? REG_MAX : r_stir_minutes;
    assign delay    = (r_low_delay > REG_MAX) ? REG_MAX : r_low_delay;
    assign low_thr  = LOW_TICKS_W'(delay) * LOW_TICKS_W'(TICKS_PER_SECOND);
    assign stir_inc = (r_stir_ticks == '1) ? r_stir_ticks : r_stir_ticks + 1'b1;
    assign low_inc  = (r_low_ticks == '1) ? r_low_ticks : r_low_ticks + 1'b1;

    always_comb begin
        logic stir_a;
        logic pump_a;
        logic clear_ok;

        // Liquid level check.
        if (i_tick.level_low) begin
            n_low_ticks = low_inc;
            n_low_alarm = r_low_alarm || (low_inc >= low_thr);
        end else begin
            n_low_ticks = '0;
            n_low_alarm = 1'b0;
        end

        // Toggles on press edges.
        stir_a = r_stir_run ^ (i_tick.stir_button_down && r_stir_up);
        pump_a = r_pump_run ^ (i_tick.pump_button_down && r_pump_up);

        // Relays take the drive decided before any stop later in the pass.
        n_stir_relay = stir_a;
        n_pump_relay = pump_a;
        n_status     = ST_IDLE;
        n_latch      = r_latch;
        n_stir_run   = stir_a;
        n_pump_run   = pump_a;

        if (stir_a) begin
            n_status = ST_STIR_RUNNING;
        end
        if (i_tick.stir_fault) begin
            n_latch    = 1'b1;
            n_stir_run = 1'b0;
            n_status   = ST_STIR_FAULT;
        end
        if (pump_a) begin
            n_status = ST_PUMP_RUNNING;
        end
        if (i_tick.pump_fault) begin
            n_latch    = 1'b1;
            n_pump_run = 1'b0;
            n_status   = ST_PUMP_FAULT;
        end
        if (n_stir_run && n_pump_run) begin
            n_status = ST_BOTH_RUNNING;
        end
        if (i_tick.stir_fault && i_tick.pump_fault) begin
            n_status = ST_BOTH_FAULTED;
        end
        if (n_low_alarm) begin
            n_latch    = 1'b1;
            n_pump_run = 1'b0;
            n_status   = ST_LOW_LIQUID;
        end
        if (i_tick.power_fault) begin
            n_latch  = 1'b1;
            n_status = ST_POWER_FAULT;
        end

        // Stirrer run timing. The stop fires only on an exact minute match.
        n_left       = '0;
        n_stir_ticks = '0;
        n_stir_min   = '0;
        if (n_stir_run) begin
            n_stir_ticks = stir_inc;
            n_stir_min   = r_stir_min;
            if (stir_inc >= STIR_TICKS_W'(TICKS_PER_MINUTE)) begin
                n_stir_min   = (r_stir_min == '1) ? r_stir_min : r_stir_min + 1'b1;
                n_stir_ticks = '0;
            end
            if (limit != '0) begin
                if (n_stir_min == limit) begin
                    n_stir_run   = 1'b0;
                    n_stir_min   = '0;
                    n_stir_ticks = '0;
                end
                if (n_stir_run) begin
                    n_status = n_pump_run ? ST_BOTH_TIMED : ST_STIR_TIMED;
                    n_left   = (n_stir_min < limit) ? limit - n_stir_min : '0;
                end
            end else begin
                n_stir_min   = '0;
                n_stir_ticks = '0;
            end
        end

        // Alarm clear.
        clear_ok = !i_tick.stir_fault && !i_tick.pump_fault && !i_tick.power_fault
                   && !i_tick.level_low;
        if (i_tick.alarm_clear_down || clear_ok) begin
            n_latch = 1'b0;
        end
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stir_run   <= 1'b0;
            r_pump_run   <= 1'b0;
            r_stir_up    <= 1'b1;
            r_pump_up    <= 1'b1;
            r_low_ticks  <= '0;
            r_low_alarm  <= 1'b0;
            r_latch      <= 1'b0;
            r_stir_ticks <= '0;
            r_stir_min   <= '0;
        end else if (accept) begin
            r_stir_run   <= n_stir_run;
            r_pump_run   <= n_pump_run;
            r_stir_up    <= !i_tick.stir_button_down;
            r_pump_up    <= !i_tick.pump_button_down;
            r_low_ticks  <= n_low_ticks;
            r_low_alarm  <= n_low_alarm;
            r_latch      <= n_latch;
            r_stir_ticks <= n_stir_ticks;
            r_stir_min   <= n_stir_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_stir   <= n_stir_relay;
            r_out_pump   <= n_pump_relay;
            r_out_buzz   <= n_latch || i_tick.alarm_clear_down;
            r_out_alarm  <= n_latch;
            r_out_status <= n_status;
            r_out_left   <= n_left;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.stir_relay_on = r_out_stir;
    assign o_res.pump_relay_on = r_out_pump;
    assign o_res.buzzer_on     = r_out_buzz;
    assign o_res.alarm_active  = r_out_alarm;
    assign o_res.status_code   = r_out_status;
    assign o_res.minutes_left  = r_out_left;

    // ----------------------------------------------------------- assertions
    `SPIC_ASSERT_SAME(a_left_only_timed, r_out_valid && (r_out_left != '0), (r_out_status == ST_STIR_TIMED) || (r_out_status == ST_BOTH_TIMED))
    `SPIC_ASSERT_SAME(a_alarm_sounds, r_out_valid && r_out_alarm, r_out_buzz)
    `SPIC_ASSERT_SAME(a_low_alarm_counts, r_low_alarm, r_low_ticks != '0)
    `SPIC_ASSERT_NEXT(a_stopped_timer_clear, accept && !n_stir_run, (r_stir_ticks == '0) && (r_stir_min == '0))

endmodule
`default_nettype wire

// ===== test/tb_stirrer_pump_interlock_controller_top.sv =====
// -----------------------------------------------------------------------------
// tb_stirrer_pump_interlock_controller_top
// Self-checking bench for the stirrer and pump interlock controller.
// -----------------------------------------------------------------------------
// Tick requests are driven on the input channel with random gaps, and results
// are taken with random back-pressure. A scoreboard keeps its own copy of the
// controller state and registers, predicts every pass and compares each
// result field by field. A short directed sequence is followed by random
// phases under several register settings.
// -----------------------------------------------------------------------------
module tb_stirrer_pump_interlock_controller_top;
    import spic_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int RANDOM_TICKS    = 145;
    localparam int LONG_HOLD       = 80;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int LOW_TICKS_SAT   = (1 << LOW_TICKS_W) - 1;
    localparam int STIR_TICKS_SAT  = (1 << STIR_TICKS_W) - 1;
    localparam int MINUTES_SAT     = (1 << MINUTES_W) - 1;

    // Field order matches the packed literals of the directed sequence.
    typedef struct packed {
        logic stir_button_down;
        logic pump_button_down;
        logic stir_fault;
        logic pump_fault;
        logic power_fault;
        logic level_low;
        logic alarm_clear_down;
    } tick_req_t;

    typedef struct packed {
        logic                 stir_relay_on;
        logic                 pump_relay_on;
        logic                 buzzer_on;
        logic                 alarm_active;
        t_status              status_code;
        logic [MINUTES_W-1:0] minutes_left;
    } pass_result_t;

    class interlock_scoreboard;
        logic [REG_W-1:0] run_minutes_reg;
        logic [REG_W-1:0] low_delay_reg;
        bit               stir_running;
        bit               pump_running;
        bit               stir_last_up;
        bit               pump_last_up;
        bit               low_alarm;
        bit               alarm_latch;
        int unsigned      low_ticks;
        int unsigned      stir_ticks;
        int unsigned      stir_minutes;
        pass_result_t     expected_passes[$];
        int unsigned      fail_count;

        function new();
            run_minutes_reg = '0;
            low_delay_reg   = '0;
            stir_running    = 1'b0;
            pump_running    = 1'b0;
            stir_last_up    = 1'b1;
            pump_last_up    = 1'b1;
            low_alarm       = 1'b0;
            alarm_latch     = 1'b0;
            low_ticks       = 0;
            stir_ticks      = 0;
            stir_minutes    = 0;
            fail_count      = 0;
        endfunction

        function void set_register(logic idx, logic [DATA_W-1:0] data);
            if (idx == REG_STIR_RUN_MINUTES) begin
                run_minutes_reg = data[REG_W-1:0];
            end else begin
                low_delay_reg = data[REG_W-1:0];
            end
        endfunction

        function int pending();
            return expected_passes.size();
        endfunction

        // Runs one control pass on the local state and queues its result.
        function void note_tick(tick_req_t t);
            pass_result_t     r;
            logic [REG_W-1:0] limit;
            logic [REG_W-1:0] delay;
            int unsigned      threshold;

            r = '0;
            r.status_code = ST_IDLE;
            limit = (run_minutes_reg > REG_MAX) ? REG_MAX : run_minutes_reg;
            delay = (low_delay_reg > REG_MAX) ? REG_MAX : low_delay_reg;

            if (stir_ticks < STIR_TICKS_SAT) stir_ticks++;
            if (low_ticks < LOW_TICKS_SAT) low_ticks++;

            if (t.level_low) begin
                threshold = int'(delay) * TICKS_PER_SECOND;
                if (low_ticks >= threshold) low_alarm = 1'b1;
            end else begin
                low_ticks = 0;
                low_alarm = 1'b0;
            end

            if (t.stir_button_down && stir_last_up) stir_running = !stir_running;
            stir_last_up = !t.stir_button_down;
            if (t.pump_button_down && pump_last_up) pump_running = !pump_running;
            pump_last_up = !t.pump_button_down;

            // Later checks override the status; relays keep the earlier drive.
            if (stir_running) begin
                r.stir_relay_on = 1'b1;
                r.status_code = ST_STIR_RUNNING;
            end
            if (t.stir_fault) begin
                alarm_latch = 1'b1;
                stir_running = 1'b0;
                r.status_code = ST_STIR_FAULT;
            end
            if (pump_running) begin
                r.pump_relay_on = 1'b1;
                r.status_code = ST_PUMP_RUNNING;
            end
            if (t.pump_fault) begin
                alarm_latch = 1'b1;
                pump_running = 1'b0;
                r.status_code = ST_PUMP_FAULT;
            end
            if (stir_running && pump_running) r.status_code = ST_BOTH_RUNNING;
            if (t.stir_fault && t.pump_fault) r.status_code = ST_BOTH_FAULTED;
            if (low_alarm) begin
                alarm_latch = 1'b1;
                pump_running = 1'b0;
                r.status_code = ST_LOW_LIQUID;
            end
            if (t.power_fault) begin
                alarm_latch = 1'b1;
                r.status_code = ST_POWER_FAULT;
            end

            if (stir_running) begin
                if (stir_ticks >= TICKS_PER_MINUTE) begin
                    if (stir_minutes < MINUTES_SAT) stir_minutes++;
                    stir_ticks = 0;
                end
                if (limit != 0) begin
                    // The stop fires only on exact equality with the limit.
                    if (stir_minutes == limit) begin
                        stir_running = 1'b0;
                        stir_minutes = 0;
                        stir_ticks = 0;
                    end
                    if (stir_running) begin
                        r.status_code = pump_running ? ST_BOTH_TIMED : ST_STIR_TIMED;
                        r.minutes_left = (stir_minutes < limit) ?
                                         MINUTES_W'(limit - stir_minutes) : '0;
                    end
                end else begin
                    stir_minutes = 0;
                    stir_ticks = 0;
                end
            end else begin
                stir_ticks = 0;
                stir_minutes = 0;
            end

            if (t.alarm_clear_down) alarm_latch = 1'b0;
            if (!t.stir_fault && !t.pump_fault && !t.power_fault && !t.level_low) begin
                alarm_latch = 1'b0;
            end

            r.buzzer_on = alarm_latch || t.alarm_clear_down;
            r.alarm_active = alarm_latch;
            expected_passes.push_back(r);
        endfunction

        function void check_result(pass_result_t got);
            pass_result_t want;

            if (expected_passes.size() == 0) begin
                $error("result arrived with no tick request pending");
                fail_count++;
                return;
            end
            want = expected_passes.pop_front();
            if (got.stir_relay_on !== want.stir_relay_on) begin
                $error("stir_relay_on: expected %0d, got %0d",
                       want.stir_relay_on, got.stir_relay_on);
                fail_count++;
            end
            if (got.pump_relay_on !== want.pump_relay_on) begin
                $error("pump_relay_on: expected %0d, got %0d",
                       want.pump_relay_on, got.pump_relay_on);
                fail_count++;
            end
            if (got.buzzer_on !== want.buzzer_on) begin
                $error("buzzer_on: expected %0d, got %0d", want.buzzer_on, got.buzzer_on);
                fail_count++;
            end
            if (got.alarm_active !== want.alarm_active) begin
                $error("alarm_active: expected %0d, got %0d",
                       want.alarm_active, got.alarm_active);
                fail_count++;
            end
            if (got.status_code !== want.status_code) begin
                $error("status_code: expected %0d, got %0d",
                       want.status_code, got.status_code);
                fail_count++;
            end
            if (got.minutes_left !== want.minutes_left) begin
                $error("minutes_left: expected %0d, got %0d",
                       want.minutes_left, got.minutes_left);
                fail_count++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    spic_in_if  tick_if();
    spic_out_if res_if();

    interlock_scoreboard sb = new();

    bit long_hold;
    bit level_state;
    int quiet_cycles;

    // Press, hold, fault and clear patterns; each line is one tick.
    logic [6:0] directed_ticks [0:19] = '{
        7'b0000000,  // idle
        7'b1000000,  // stirrer press starts it
        7'b1000000,  // held button does not toggle again
        7'b0100000,  // pump press, both running
        7'b0010000,  // stirrer fault stops it and latches the alarm
        7'b0000000,  // all clear releases the latch
        7'b1001000,  // stirrer press with a pump fault
        7'b0011000,  // both faulted
        7'b0000001,  // clear button alone
        7'b0100010,  // pump press while low, zero delay alarms at once
        7'b0000010,  // liquid stays low
        7'b0000011,  // low with the clear button held
        7'b0000100,  // power fault
        7'b0000101,  // power fault with clear held
        7'b1100000,  // both presses together
        7'b0000000,
        7'b1111111,  // every input active
        7'b1111111,
        7'b0000001,
        7'b0000000
    };

    stirrer_pump_interlock_controller_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_tick  (tick_if),
        .o_res   (res_if)
    );

    initial clk = 1'b0;
    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int pick_idle();
        int r;

        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [DATA_W-1:0] with_noise(logic [REG_W-1:0] value);
        return ($urandom & ~DATA_W'((1 << REG_W) - 1)) | DATA_W'(value);
    endfunction

    // Mostly plausible panel activity: sparse presses and faults, and a
    // level sensor that stays put for long runs. Some ticks are pure noise.
    function automatic tick_req_t random_tick();
        tick_req_t t;

        if ($urandom_range(0, 99) < 10) begin
            t = tick_req_t'(7'($urandom_range(0, 127)));
        end else begin
            if ($urandom_range(0, 99) < 2) level_state = !level_state;
            t.stir_button_down = $urandom_range(0, 99) < 25;
            t.pump_button_down = $urandom_range(0, 99) < 25;
            t.stir_fault       = $urandom_range(0, 99) < 5;
            t.pump_fault       = $urandom_range(0, 99) < 5;
            t.power_fault      = $urandom_range(0, 99) < 4;
            t.level_low        = level_state;
            t.alarm_clear_down = $urandom_range(0, 99) < 8;
        end
        return t;
    endfunction

    task automatic send_tick(input tick_req_t t);
        int gap;

        gap = pick_idle();
        @(negedge clk);
        if (gap > 0) begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_if.valid            <= 1'b1;
        tick_if.stir_button_down <= t.stir_button_down;
        tick_if.pump_button_down <= t.pump_button_down;
        tick_if.stir_fault       <= t.stir_fault;
        tick_if.pump_fault       <= t.pump_fault;
        tick_if.power_fault      <= t.power_fault;
        tick_if.level_low        <= t.level_low;
        tick_if.alarm_clear_down <= t.alarm_clear_down;
        do @(posedge clk); while (!tick_if.ready);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        tick_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_register(idx, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_phase(input bit with_pressure);
        for (int i = 0; i < RANDOM_TICKS; i++) begin
            if (with_pressure && i == 40) long_hold = 1'b1;
            if (with_pressure && i == 100) wait_drain();
            send_tick(random_tick());
        end
    endtask

    // Result side: random back-pressure, plus one long hold on request.
    initial begin
        int stall;

        stall = 0;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (long_hold) begin
                long_hold = 1'b0;
                stall = LONG_HOLD;
            end else if (stall == 0) begin
                stall = pick_idle();
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                stall--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (res_if.valid && res_if.ready) begin
                sb.check_result('{res_if.stir_relay_on, res_if.pump_relay_on,
                                  res_if.buzzer_on, res_if.alarm_active,
                                  res_if.status_code, res_if.minutes_left});
            end
            if (tick_if.valid && tick_if.ready) begin
                sb.note_tick('{tick_if.stir_button_down, tick_if.pump_button_down,
                               tick_if.stir_fault, tick_if.pump_fault,
                               tick_if.power_fault, tick_if.level_low,
                               tick_if.alarm_clear_down});
            end
        end
    end

    always @(posedge clk) begin
        if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        quiet_cycles = 0;
        long_hold = 1'b0;
        level_state = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tick_if.valid = 1'b0;
        tick_if.stir_button_down = 1'b0;
        tick_if.pump_button_down = 1'b0;
        tick_if.stir_fault = 1'b0;
        tick_if.pump_fault = 1'b0;
        tick_if.power_fault = 1'b0;
        tick_if.level_low = 1'b0;
        tick_if.alarm_clear_down = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Registers at their reset value: no stirrer limit, zero liquid delay.
        foreach (directed_ticks[i]) send_tick(tick_req_t'(directed_ticks[i]));

        wait_drain();
        write_reg(REG_STIR_RUN_MINUTES, with_noise(10'd5));
        write_reg(REG_LOW_LEVEL_DELAY, with_noise(10'd1));
        random_phase(1'b0);

        // All ones: both registers act as the ceiling value of 999.
        wait_drain();
        write_reg(REG_STIR_RUN_MINUTES, '1);
        write_reg(REG_LOW_LEVEL_DELAY, '1);
        random_phase(1'b1);

        wait_drain();
        write_reg(REG_STIR_RUN_MINUTES, with_noise(REG_W'($urandom_range(1, 3))));
        write_reg(REG_LOW_LEVEL_DELAY, '0);
        random_phase(1'b0);

        wait_drain();
        repeat (4) @(posedge clk);
        if (sb.fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
